// File: rtl/naive_bayes_categorical_classifier_defines.svh
// Assertion macros for the naive Bayes classifier.
`ifndef NAIVE_BAYES_CATEGORICAL_CLASSIFIER_DEFINES_SVH
`define NAIVE_BAYES_CATEGORICAL_CLASSIFIER_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define NB_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define NB_ASSERT_NXT(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
		else $error("assertion failed");
`endif

// File: rtl/nbc_pkg.sv
// Package with constants and types of the naive Bayes classifier.
`default_nettype none
package nbc_pkg;
	localparam int MAX_RECORDS = 255;
	localparam int VALUES_PER_ATTR = 16;
	localparam int CNT_W = 8;
	localparam int PROD_W = 56;
	localparam logic [1:0] LABEL_NO = 2'd0;
	localparam logic [1:0] LABEL_YES = 2'd1;
	localparam logic KIND_TRAIN = 1'b0;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [PROD_W-1:0] prod_t;
	// Start and busy between the top level and the serial multiplier.
	typedef struct packed {
		logic start;
		logic busy;
	} mul_ctl_t;
endpackage
`default_nettype wire

// File: rtl/nbc_mul.sv
// Bit-serial shift-and-add multiplier: a 56-bit operand times an 8-bit one.
`default_nettype none
module nbc_mul (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire nbc_pkg::prod_t a,
	input  wire nbc_pkg::cnt_t  b,
	output nbc_pkg::mul_ctl_t   ctl,
	output nbc_pkg::prod_t      p
);
	import nbc_pkg::*;
	prod_t acc_q;
	prod_t a_q;
	cnt_t  b_q;
	logic [3:0] cnt_q;
	logic busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= 4'd8;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 4'd1;
			if (cnt_q == 4'd1) busy_q <= 1'b0;
		end
	end

	// One multiplier bit per cycle, least significant first.
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q <= a;
			b_q <= b;
		end else if (busy_q) begin
			if (b_q[0]) acc_q <= acc_q + a_q;
			a_q <= {a_q[PROD_W-2:0], 1'b0};
			b_q <= {1'b0, b_q[CNT_W-1:1]};
		end
	end

	assign ctl.start = start;
	assign ctl.busy = busy_q;
	assign p = acc_q;
endmodule
`default_nettype wire

// File: rtl/naive_bayes_categorical_classifier.sv
// Top level: count tables, totals, query sequencer around a serial multiplier.
// Training item with a yes or no label: a read step and a write step per attribute, in turn.
// Other training items leave the tables untouched. No training item gives a result.
// Query item: eight table reads, fourteen serial multiplies, a compare and an
// output load. The next item is taken once the output register has loaded.
// Reset is asynchronous and active low; a clearing pass over all 128 entries follows with the input stalled.
`default_nettype none
module naive_bayes_categorical_classifier (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic       kind,
	input  wire logic [3:0] age_code,
	input  wire logic [3:0] income_code,
	input  wire logic [3:0] student_code,
	input  wire logic [3:0] credit_code,
	input  wire logic [1:0] label,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            predict_yes,
	output logic [7:0]      total_records,
	output logic [7:0]      yes_total,
	output logic [7:0]      no_total,
	output logic [7:0]      age_yes,
	output logic [7:0]      age_no,
	output logic [7:0]      income_yes,
	output logic [7:0]      income_no,
	output logic [7:0]      student_yes,
	output logic [7:0]      student_no,
	output logic [7:0]      credit_yes,
	output logic [7:0]      credit_no
);
	import nbc_pkg::*;
	`include "naive_bayes_categorical_classifier_defines.svh"

	// Sequencer states.
	localparam logic [3:0] ST_CLR   = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_TRAIN = 4'd2;
	localparam logic [3:0] ST_READ  = 4'd3;
	localparam logic [3:0] ST_MSTART = 4'd4;
	localparam logic [3:0] ST_MWAIT = 4'd5;
	localparam logic [3:0] ST_CMP   = 4'd6;
	localparam logic [3:0] ST_OUT   = 4'd7;

	logic [3:0] state_q;
	logic [6:0] clr_q;
	logic [2:0] rd_q;
	logic [3:0] step_q;

	// The count memory: 128 entries, one read and one write port.
	cnt_t mem [0:127];
	cnt_t rdata_q;
	logic [6:0] raddr;
	logic       we;
	logic [6:0] waddr;
	cnt_t       wdata;

	cnt_t rec_q, yes_q, no_q;
	logic       kind_q;
	logic [3:0] code_q [0:3];
	logic [1:0] label_q;
	logic [1:0] tattr_q;
	cnt_t cy_q [0:3];
	cnt_t cn_q [0:3];
	prod_t lhs_q, rhs_q;
	logic pred_q;

	// A code at or above the number of values per attribute is neither stored nor matched.
	function automatic logic code_ok(input logic [3:0] code);
		code_ok = 5'(code) < 5'(VALUES_PER_ATTR);
	endfunction

	logic accept;
	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);

	// In ST_OUT the output register loads when it is empty or its item leaves this cycle.
	logic out_load;
	assign out_load = (state_q == ST_OUT) && (!out_valid || !out_stall);

	// Training updates each attribute in turn: read cycle, then write cycle; a query reads yes, then no.
	always_comb begin
		raddr = '0;
		if (state_q == ST_TRAIN)
			raddr = {tattr_q, code_q[tattr_q], label_q[0]};
		else
			raddr = {rd_q[2:1], code_q[rd_q[2:1]], ~rd_q[0]};
	end

	logic tr_phase_q;
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
		if (we) mem[waddr] <= wdata;
	end

	always_comb begin
		we = 1'b0;
		waddr = {tattr_q, code_q[tattr_q], label_q[0]};
		wdata = rdata_q + 8'd1;
		if (state_q == ST_CLR) begin
			we = 1'b1;
			waddr = clr_q;
			wdata = '0;
		end else if (state_q == ST_TRAIN && tr_phase_q && code_ok(code_q[tattr_q])) begin
			we = 1'b1;
		end
	end

	// Multiplier operand sequencing: steps 0-3 build prod_yes, 4-6 times n^3,
	// 7-10 prod_no, 11-13 times y^3; each ends in lhs or rhs.
	logic mul_start;
	prod_t mul_a;
	cnt_t mul_b;
	mul_ctl_t mul_ctl;
	prod_t mul_p;
	prod_t acc_q;

	always_comb begin
		mul_a = acc_q;
		case (step_q) inside
			[4'd0:4'd3]:  mul_b = cy_q[step_q[1:0]];
			[4'd4:4'd6]:  mul_b = no_q;
			[4'd7:4'd10]: mul_b = cn_q[2'(step_q - 4'd7)];
			default:      mul_b = yes_q;
		endcase
	end
	assign mul_start = (state_q == ST_MSTART);

	nbc_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start),
		.a(mul_a), .b(mul_b), .ctl(mul_ctl), .p(mul_p)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q <= '0;
			rd_q <= '0;
			step_q <= '0;
			tr_phase_q <= 1'b0;
			tattr_q <= '0;
			rec_q <= '0;
			yes_q <= '0;
			no_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_load) out_valid <= 1'b1;
			else if (out_valid && !out_stall) out_valid <= 1'b0;
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 7'd1;
					if (clr_q == 7'd127) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept) begin
						if (kind == KIND_TRAIN) begin
							if (rec_q < 8'(MAX_RECORDS)) begin
								rec_q <= rec_q + 8'd1;
								if (label == LABEL_YES) yes_q <= yes_q + 8'd1;
								if (label == LABEL_NO) no_q <= no_q + 8'd1;
								if (label == LABEL_YES || label == LABEL_NO) begin
									state_q <= ST_TRAIN;
									tattr_q <= '0;
									tr_phase_q <= 1'b0;
								end
							end
						end else begin
							state_q <= ST_READ;
							rd_q <= '0;
						end
					end
				end
				ST_TRAIN: begin
					tr_phase_q <= ~tr_phase_q;
					if (tr_phase_q) begin
						tattr_q <= tattr_q + 2'd1;
						if (tattr_q == 2'd3) state_q <= ST_IDLE;
					end
				end
				ST_READ: begin
					// Read issued at rd, data lands in rdata_q in the next cycle.
					rd_q <= rd_q + 3'd1;
					if (rd_q == 3'd7) begin
						state_q <= ST_MSTART;
						step_q <= '0;
					end
				end
				ST_MSTART: state_q <= ST_MWAIT;
				ST_MWAIT: begin
					if (!mul_ctl.busy) begin
						step_q <= step_q + 4'd1;
						if (step_q == 4'd13) state_q <= ST_CMP;
						else state_q <= ST_MSTART;
					end
				end
				ST_CMP: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers.
	logic [1:0] prev_a;
	logic       prev_c;
	logic       prev_ok;
	always_comb begin
		prev_a = 2'((rd_q - 3'd1) >> 1);
		prev_c = rd_q[0];
		prev_ok = code_ok(code_q[prev_a]);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind;
			code_q[0] <= age_code;
			code_q[1] <= income_code;
			code_q[2] <= student_code;
			code_q[3] <= credit_code;
			label_q <= label;
		end
		// Reads issued at rd 0..7 return in the next cycle; capture them.
		if (state_q == ST_READ && rd_q != 3'd0) begin
			if (prev_c) cy_q[prev_a] <= prev_ok ? rdata_q : '0;
			else cn_q[prev_a] <= prev_ok ? rdata_q : '0;
		end
		if (state_q == ST_MSTART && step_q == 4'd0) begin
			cn_q[3] <= prev_ok ? rdata_q : '0;
		end
		if (state_q == ST_READ && rd_q == 3'd7) acc_q <= prod_t'(1);
		if (state_q == ST_MWAIT && !mul_ctl.busy) begin
			if (step_q == 4'd6) begin
				lhs_q <= mul_p;
				acc_q <= prod_t'(1);
			end else if (step_q == 4'd13) begin
				rhs_q <= mul_p;
			end else begin
				acc_q <= mul_p;
			end
		end
		if (state_q == ST_CMP) begin
			if (yes_q == '0) pred_q <= 1'b0;
			else if (no_q == '0) pred_q <= (cy_q[0] != '0) && (cy_q[1] != '0) &&
				(cy_q[2] != '0) && (cy_q[3] != '0);
			else pred_q <= lhs_q > rhs_q;
		end
		if (out_load) begin
			predict_yes <= pred_q;
			total_records <= rec_q;
			yes_total <= yes_q;
			no_total <= no_q;
			age_yes <= cy_q[0];
			age_no <= cn_q[0];
			income_yes <= cy_q[1];
			income_no <= cn_q[1];
			student_yes <= cy_q[2];
			student_no <= cn_q[2];
			credit_yes <= cy_q[3];
			credit_no <= cn_q[3];
		end
	end

	// The memory is never written while a query reads it.
	`NB_ASSERT_IMP(a_no_write_in_query, clk, arst_n, state_q == ST_READ, !we)
	// Training never pushes the record total past capacity.
	`NB_ASSERT_IMP(a_cap, clk, arst_n, 1'b1, rec_q <= 8'(MAX_RECORDS))
	// An item is never taken while a result is being built.
	`NB_ASSERT_NXT(a_busy, clk, arst_n, state_q == ST_MWAIT && kind_q, in_stall)
endmodule
`default_nettype wire
